### hdl/skt_pkg.sv
// shared types and constants for the skeleton thinning subpass
package skt_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int MIN_DIM       = 3;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    localparam logic [COUNT_W-1:0] B_LOW  = 4'd2;
    localparam logic [COUNT_W-1:0] B_HIGH = 4'd6;

    typedef struct packed {
        logic is_flush;
        logic emit;
        logic use_older;
        logic interior;
        logic last;
    } item_ctl_t;

endpackage

### hdl/skt_line_store.sv
// two-row line store, one write port and two registered write-first read ports
module skt_line_store #(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [1:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_a_addr,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [1:0]        rd_a_data,
    output logic [1:0]        rd_b_data
);

    logic [1:0] mem [0:DEPTH-1];
    logic [1:0] rd_a_reg;
    logic [1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && wr_addr == rd_a_addr) ? wr_data : mem[rd_a_addr];
            rd_b_reg <= (wr_en && wr_addr == rd_b_addr) ? wr_data : mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

### hdl/skt_zs_test.sv
// zhang-suen deletion test on a 3x3 window
module skt_zs_test (
    input  logic [8:0] window,
    input  logic       subiteration,
    output logic       del_ok
);
    import skt_pkg::*;

    logic [8:0]         ring;
    logic [COUNT_W-1:0] a_cnt;
    logic [COUNT_W-1:0] b_cnt;
    logic               p2, p4, p6, p8;
    logic               prod_ok;

    assign p2 = window[3];
    assign p4 = window[1];
    assign p6 = window[5];
    assign p8 = window[7];

    // ring order p2 p3 p4 p5 p6 p7 p8 p9 p2
    assign ring = {window[3], window[0], window[1], window[2], window[5],
                   window[8], window[7], window[6], window[3]};

    always_comb
    begin
        a_cnt = '0;
        b_cnt = '0;
        for (int k = 8; k > 0; k--)
        begin
            b_cnt = b_cnt + COUNT_W'(ring[k]);
            if (!ring[k] && ring[k-1])
            begin
                a_cnt = a_cnt + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (subiteration)
        begin
            prod_ok = !(p2 && p4 && p8) && !(p2 && p6 && p8);
        end
        else
        begin
            prod_ok = !(p2 && p4 && p6) && !(p4 && p6 && p8);
        end
    end

    assign del_ok = window[4] && (a_cnt == COUNT_W'(1)) && (b_cnt >= B_LOW)
                    && (b_cnt <= B_HIGH) && prod_ok;

endmodule

### hdl/skt_pos_ctrl.sv
// configuration registers, raster position counters and pending-word count
module skt_pos_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_fire,
    input  logic [skt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_fire,
    input  logic                            in_op,
    output logic                            subiteration,
    output logic [COL_W-1:0]                in_col,
    output logic [COL_W-1:0]                out_col,
    output skt_pkg::item_ctl_t              ctl
);
    import skt_pkg::*;

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH + 2);
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    logic             subiter_reg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [CNT_W-1:0] pend_reg;

    logic [WID_W-1:0] w_clamp;
    logic [HGT_W-1:0] h_clamp;
    logic             is_flush;
    logic             full;
    logic             emit;
    logic             in_last_col;
    logic             out_last_col;
    logic             out_last_row;

    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(MIN_DIM))
        begin
            w_clamp = WID_W'(MIN_DIM);
            h_clamp = HGT_W'(MIN_DIM);
        end
        else
        begin
            w_clamp = (32'(cfg_data) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_data);
            h_clamp = (32'(cfg_data) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(cfg_data);
        end
    end

    assign is_flush     = (in_op == OP_FLUSH);
    assign full         = (pend_reg == CNT_W'(width_reg) + CNT_W'(1));
    assign emit         = is_flush ? (pend_reg != '0) : full;
    assign in_last_col  = (WID_W'(in_col_reg) == width_reg - WID_W'(1));
    assign out_last_col = (WID_W'(out_col_reg) == width_reg - WID_W'(1));
    assign out_last_row = (HGT_W'(out_row_reg) == height_reg - HGT_W'(1));

    always_comb
    begin
        ctl.is_flush  = is_flush;
        ctl.emit      = emit;
        ctl.use_older = full;
        ctl.interior  = !is_flush && (out_col_reg != '0) && (out_row_reg != '0)
                        && (WID_W'(out_col_reg) < width_reg - WID_W'(1))
                        && (HGT_W'(out_row_reg) < height_reg - HGT_W'(1));
        ctl.last      = out_last_col && out_last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subiter_reg <= 1'b0;
            width_reg   <= WID_W'(RST_W);
            height_reg  <= HGT_W'(RST_H);
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_SUBITER:
                begin
                    subiter_reg <= cfg_data[0];
                end
                CFG_WIDTH:
                begin
                    width_reg   <= w_clamp;
                    in_col_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    pend_reg    <= '0;
                end
                CFG_HEIGHT:
                begin
                    height_reg  <= h_clamp;
                    in_col_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    pend_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (!is_flush)
            begin
                in_col_reg <= in_last_col ? '0 : in_col_reg + COL_W'(1);
                if (!full)
                begin
                    pend_reg <= pend_reg + CNT_W'(1);
                end
            end
            else if (emit)
            begin
                pend_reg <= pend_reg - CNT_W'(1);
            end
            if (emit)
            begin
                out_col_reg <= out_last_col ? '0 : out_col_reg + COL_W'(1);
                if (out_last_col)
                begin
                    out_row_reg <= out_last_row ? '0 : out_row_reg + ROW_W'(1);
                end
            end
        end
    end

    assign subiteration = subiter_reg;
    assign in_col       = in_col_reg;
    assign out_col      = out_col_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(width_reg) + CNT_W'(1))
        else $error("pending count above one row plus one");

    a_in_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(in_col_reg) < width_reg)
        else $error("input column outside the row");

    a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(out_col_reg) < width_reg && HGT_W'(out_row_reg) < height_reg)
        else $error("output position outside the frame");

endmodule

### hdl/skeleton_thinning_subpass.sv
// top level of one zhang-suen thinning subiteration on a raster pixel stream
// a word is held in the stage-1 register, and its result word then leaves the output register
// throughput: one word per cycle, in and out, while out_ready does not hold the output; set by the single window stage
// results lag pixels by one row plus one pixel; flush words drain what is pending
// reset clears counters, window and valid flags and restores 640x480, subiteration 0
// the line store is not cleared
module skeleton_thinning_subpass #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [skt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic                            pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            pixel_out,
    output logic                            deleted,
    output logic                            out_last
);
    import skt_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             in_fire;
    logic             cfg_fire;
    logic             subiteration;
    logic [COL_W-1:0] in_col;
    logic [COL_W-1:0] out_col;
    item_ctl_t        ctl;

    logic             s1_valid_reg;
    item_ctl_t        s1_ctl_reg;
    logic             s1_px_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [8:0]       window_reg;
    logic [8:0]       window_next;

    logic [1:0]       rd_a_data;
    logic [1:0]       rd_b_data;
    logic             s1_go;
    logic             out_free;
    logic             wr_en;
    logic             del_ok;
    logic             res_pixel;
    logic             res_del;

    logic             out_valid_reg;
    logic             pixel_out_reg;
    logic             deleted_reg;
    logic             out_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (!s1_ctl_reg.emit || out_free);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;
    assign wr_en    = s1_go && !s1_ctl_reg.is_flush;

    skt_pos_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_fire     (cfg_fire),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .in_op        (op),
        .subiteration (subiteration),
        .in_col       (in_col),
        .out_col      (out_col),
        .ctl          (ctl)
    );

    // bit 0 holds the previous row, bit 1 the row before it
    skt_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (s1_addr_reg),
        .wr_data   ({rd_a_data[0], s1_px_reg}),
        .rd_en     (in_fire),
        .rd_a_addr (in_col),
        .rd_b_addr (out_col),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // newest column enters bits 2..0: current, previous, older row
    assign window_next = {window_reg[5:0], s1_px_reg, rd_a_data[0], rd_a_data[1]};

    skt_zs_test u_test (
        .window       (window_next),
        .subiteration (subiteration),
        .del_ok       (del_ok)
    );

    always_comb
    begin
        if (s1_ctl_reg.is_flush)
        begin
            res_pixel = s1_ctl_reg.use_older ? rd_b_data[1] : rd_b_data[0];
            res_del   = 1'b0;
        end
        else
        begin
            res_del   = s1_ctl_reg.interior && del_ok;
            res_pixel = window_next[4] && !res_del;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                window_reg <= window_next;
            end
            if (s1_go && s1_ctl_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctl_reg  <= ctl;
            s1_px_reg   <= pixel_in;
            s1_addr_reg <= in_col;
        end
        if (s1_go && s1_ctl_reg.emit)
        begin
            pixel_out_reg <= res_pixel;
            deleted_reg   <= res_del;
            out_last_reg  <= s1_ctl_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign deleted   = deleted_reg;
    assign out_last  = out_last_reg;

    a_del_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && deleted_reg |-> !pixel_out_reg)
        else $error("deleted word carries an object pixel");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_ctl_reg.emit && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_border_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_ctl_reg.emit && !s1_ctl_reg.interior |=> !deleted_reg)
        else $error("border or flushed word marked deleted");

endmodule
